>>> sv/lpsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED panel pixel scan mapper package
// Shared types, register indexes, reset values and default sizes.
// ----------------------------------------------------------------------------
package lpsm_pkg;

    localparam int FRAME_PIXELS_DEF = 65536;
    localparam int TILE_COLUMNS_DEF = 6;
    localparam int TILE_ROWS_DEF    = 12;

    localparam int PIXEL_W   = 24;
    localparam int COLOR_W   = 8;
    localparam int SECTION_W = 6;
    localparam int SIZE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int UNIVERSE_W = 8;
    localparam int SLOT_W    = 7;
    localparam int PANEL_W   = 7;
    localparam int ADDR_IN_W = 16;

    localparam logic [SECTION_W-1:0] FIRST_SECTION_RST = 6'd0;
    localparam logic [SECTION_W-1:0] LAST_SECTION_RST  = 6'd0;
    localparam logic [SIZE_W-1:0]    FRAME_WIDTH_RST   = 8'd12;
    localparam logic [SIZE_W-1:0]    FRAME_HEIGHT_RST  = 8'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_SECTION = 2'd0,
        CFG_LAST_SECTION  = 2'd1,
        CFG_FRAME_WIDTH   = 2'd2,
        CFG_FRAME_HEIGHT  = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START_COL,
        S_WAIT_COL,
        S_START_ROW,
        S_WAIT_ROW,
        S_ROW,
        S_ADDR,
        S_READ,
        S_OUT
    } t_state;

endpackage

>>> sv/lpsm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Divides an unsigned dividend by the 8-bit frame width, one quotient bit
// per cycle. Done pulses for one cycle when quotient and remainder are final.
// ----------------------------------------------------------------------------
module lpsm_divider #(
    parameter int DW = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DW-1:0]              i_dividend,
    input  logic [lpsm_pkg::SIZE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [DW-1:0]              o_quotient,
    output logic [lpsm_pkg::SIZE_W-1:0] o_remainder
);

    localparam int CW = $clog2(DW + 1);
    localparam int SW = lpsm_pkg::SIZE_W;

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_done;
    logic          n_done;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] n_quo;
    logic [SW-1:0] r_rem;
    logic [SW-1:0] n_rem;
    logic [SW:0]   shifted;
    logic          fits;

    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        fits    = (shifted >= {1'b0, i_divisor});
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_quo   = r_quo;
        n_rem   = r_rem;
        if (i_start) begin
            n_cnt = CW'(DW);
            n_quo = i_dividend;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - CW'(1);
            n_done = (r_cnt == CW'(1));
            n_quo  = {r_quo[DW-2:0], fits};
            n_rem  = fits ? SW'(shifted - {1'b0, i_divisor}) : shifted[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> sv/lpsm_frame_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame store
// Dual-port RGB pixel memory, one write port and one read port, with a registered read.
// ----------------------------------------------------------------------------
module lpsm_frame_store #(
    parameter int AW = 16
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [lpsm_pkg::PIXEL_W-1:0] i_wr_data,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [lpsm_pkg::PIXEL_W-1:0] o_rd_data
);

    logic [lpsm_pkg::PIXEL_W-1:0] r_mem [2**AW];
    logic [lpsm_pkg::PIXEL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/led_panel_pixel_scan_mapper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED panel pixel scan mapper
// Keeps an RGB frame store and reads it back in the scan order of LED tiles.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_stall   mode, address, RGB
//   out      output     o_out_valid / i_out_stall universe, slot, RGB, ends
//   cfg      input      i_cfg_valid / o_cfg_ready index, data
//
// A scan request runs the bit-serial divider twice, once for the column and
// once for the tile row (DW is 12 at the default sizes).
// Reset is synchronous and active low and clears control state only; the
// frame store holds no defined value until written.
// A stalled result stays in the output register; the next write is taken
// meanwhile, and the next scan waits only at its output load.
// FRAME_PIXELS must be a power of two.
// ----------------------------------------------------------------------------
module led_panel_pixel_scan_mapper_unit #(
    parameter int FRAME_PIXELS = lpsm_pkg::FRAME_PIXELS_DEF,
    parameter int TILE_COLUMNS = lpsm_pkg::TILE_COLUMNS_DEF,
    parameter int TILE_ROWS    = lpsm_pkg::TILE_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [lpsm_pkg::ADDR_IN_W-1:0]  i_pixel_address,
    input  logic [lpsm_pkg::COLOR_W-1:0]    i_red_in,
    input  logic [lpsm_pkg::COLOR_W-1:0]    i_green_in,
    input  logic [lpsm_pkg::COLOR_W-1:0]    i_blue_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [lpsm_pkg::UNIVERSE_W-1:0] o_universe,
    output logic [lpsm_pkg::SLOT_W-1:0]     o_slot,
    output logic [lpsm_pkg::COLOR_W-1:0]    o_red_out,
    output logic [lpsm_pkg::COLOR_W-1:0]    o_green_out,
    output logic [lpsm_pkg::COLOR_W-1:0]    o_blue_out,
    output logic                            o_packet_end,
    output logic                            o_frame_end,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lpsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lpsm_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    localparam int AW  = $clog2(FRAME_PIXELS);
    localparam int CCW = (TILE_COLUMNS > 1) ? $clog2(TILE_COLUMNS) : 1;
    localparam int RCW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
    localparam int SW  = lpsm_pkg::SIZE_W;
    localparam int PW7 = lpsm_pkg::PANEL_W;
    localparam int BW  = SW + $clog2(TILE_COLUMNS + 1);
    localparam int DW  = BW + 1;
    localparam int TRW = $clog2(TILE_ROWS + 1);
    localparam int RW  = DW + 1 + TRW + 2;
    localparam int MW  = (RW + SW + 1 > AW) ? RW + SW + 1 : AW;

    lpsm_pkg::t_state r_state;
    lpsm_pkg::t_state n_state;

    logic [lpsm_pkg::SECTION_W-1:0] r_first;
    logic [lpsm_pkg::SECTION_W-1:0] r_last;
    logic [SW-1:0]                  r_width;
    logic [SW-1:0]                  r_height;

    logic [PW7-1:0] r_pc;
    logic [CCW-1:0] r_cc;
    logic [RCW-1:0] r_rc;

    logic [SW-1:0]        r_col_pos;
    logic [DW-1:0]        r_tile_row;
    logic signed [RW-1:0] r_row_val;
    logic [AW-1:0]        r_addr;

    logic                            r_out_valid;
    logic [lpsm_pkg::UNIVERSE_W-1:0] r_universe;
    logic [lpsm_pkg::SLOT_W-1:0]     r_slot;
    logic [lpsm_pkg::PIXEL_W-1:0]    r_pixel;
    logic                            r_packet_end;
    logic                            r_frame_end;

    logic                 in_accept;
    logic                 out_free;
    logic                 empty_range;
    logic [SW-1:0]        panels;
    logic [SW-1:0]        span;
    logic                 pc_over;
    logic [SW-1:0]        panel_num;
    logic [BW-1:0]        base;
    logic [CCW-1:0]       off;
    logic [DW-1:0]        dividend;
    logic                 zero_w;
    logic [RW-1:0]        tile_term;
    logic signed [RW-1:0] row_c;
    logic signed [MW-1:0] addr_full;
    logic                 pend;
    logic                 fend;

    logic                         div_start;
    logic                         div_done;
    logic [DW-1:0]                div_quo;
    logic [SW-1:0]                div_rem;
    logic                         rd_en;
    logic                         wr_en;
    logic                         load_out;
    logic [lpsm_pkg::PIXEL_W-1:0] rd_data;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign empty_range = (r_last < r_first);
    assign span        = {2'b00, r_last} - {2'b00, r_first} + SW'(1);
    assign panels      = {span[SW-2:0], 1'b0};
    assign pc_over     = ({1'b0, r_pc} >= panels);
    assign panel_num   = {1'b0, r_first, 1'b0} + {1'b0, r_pc};
    assign base        = BW'(panel_num * TILE_COLUMNS);
    assign off         = panel_num[0] ? r_cc : (CCW'(TILE_COLUMNS - 1) - r_cc);
    assign zero_w      = (r_width == '0);
    assign tile_term   = RW'(TILE_ROWS) * (RW'(r_tile_row) + RW'(1));
    assign row_c       = $signed(RW'(r_height)) - $signed(tile_term)
                         + $signed(RW'(r_rc));
    assign addr_full   = MW'(MW'(r_row_val) * $signed(MW'(r_width)))
                         + $signed(MW'(r_col_pos));
    assign pend        = (r_cc == CCW'(TILE_COLUMNS - 1)) && (r_rc == RCW'(TILE_ROWS - 1));
    assign fend        = pend && ({1'b0, r_pc} == (panels - SW'(1)));

    always_comb begin
        dividend = DW'(base);
        if (r_state == lpsm_pkg::S_START_COL) begin
            dividend = DW'(base) + DW'(off);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpsm_pkg::S_IDLE: begin
                if (in_accept && i_mode && !empty_range) begin
                    n_state = lpsm_pkg::S_START_COL;
                end
            end
            lpsm_pkg::S_START_COL: n_state = lpsm_pkg::S_WAIT_COL;
            lpsm_pkg::S_WAIT_COL: begin
                if (div_done) begin
                    n_state = lpsm_pkg::S_START_ROW;
                end
            end
            lpsm_pkg::S_START_ROW: n_state = lpsm_pkg::S_WAIT_ROW;
            lpsm_pkg::S_WAIT_ROW: begin
                if (div_done) begin
                    n_state = lpsm_pkg::S_ROW;
                end
            end
            lpsm_pkg::S_ROW:  n_state = lpsm_pkg::S_ADDR;
            lpsm_pkg::S_ADDR: n_state = lpsm_pkg::S_READ;
            lpsm_pkg::S_READ: n_state = lpsm_pkg::S_OUT;
            lpsm_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = lpsm_pkg::S_IDLE;
                end
            end
            default: n_state = lpsm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != lpsm_pkg::S_IDLE);
        div_start  = (r_state == lpsm_pkg::S_START_COL) ||
                     (r_state == lpsm_pkg::S_START_ROW);
        rd_en      = (r_state == lpsm_pkg::S_READ);
        load_out   = (r_state == lpsm_pkg::S_OUT) && out_free;
        wr_en      = (r_state == lpsm_pkg::S_IDLE) && i_in_valid && !i_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpsm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= lpsm_pkg::FIRST_SECTION_RST;
            r_last   <= lpsm_pkg::LAST_SECTION_RST;
            r_width  <= lpsm_pkg::FRAME_WIDTH_RST;
            r_height <= lpsm_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (lpsm_pkg::t_cfg_reg'(i_cfg_index))
                lpsm_pkg::CFG_FIRST_SECTION: r_first  <= i_cfg_data[lpsm_pkg::SECTION_W-1:0];
                lpsm_pkg::CFG_LAST_SECTION:  r_last   <= i_cfg_data[lpsm_pkg::SECTION_W-1:0];
                lpsm_pkg::CFG_FRAME_WIDTH:   r_width  <= i_cfg_data;
                lpsm_pkg::CFG_FRAME_HEIGHT:  r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Counters restart when the panel counter is beyond a changed range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
            r_cc <= '0;
            r_rc <= '0;
        end else if ((r_state == lpsm_pkg::S_IDLE) && in_accept && i_mode &&
                     !empty_range && pc_over) begin
            r_pc <= '0;
            r_cc <= '0;
            r_rc <= '0;
        end else if (load_out) begin
            if (r_rc != RCW'(TILE_ROWS - 1)) begin
                r_rc <= r_rc + RCW'(1);
            end else begin
                r_rc <= '0;
                if (r_cc != CCW'(TILE_COLUMNS - 1)) begin
                    r_cc <= r_cc + CCW'(1);
                end else begin
                    r_cc <= '0;
                    r_pc <= fend ? '0 : r_pc + PW7'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == lpsm_pkg::S_WAIT_COL) && div_done) begin
            r_col_pos <= zero_w ? '0 : div_rem;
        end
        if ((r_state == lpsm_pkg::S_WAIT_ROW) && div_done) begin
            r_tile_row <= zero_w ? '0 : div_quo;
        end
        if (r_state == lpsm_pkg::S_ROW) begin
            r_row_val <= row_c;
        end
        if (r_state == lpsm_pkg::S_ADDR) begin
            r_addr <= addr_full[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_universe   <= lpsm_pkg::UNIVERSE_W'({1'b0, r_pc} + SW'(1));
            r_slot       <= lpsm_pkg::SLOT_W'(r_cc * TILE_ROWS + r_rc);
            r_pixel      <= rd_data;
            r_packet_end <= pend;
            r_frame_end  <= fend;
        end
    end

    lpsm_divider #(
        .DW(DW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_width),
        .o_done     (div_done),
        .o_quotient (div_quo),
        .o_remainder(div_rem)
    );

    lpsm_frame_store #(
        .AW(AW)
    ) u_frame_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(AW'(i_pixel_address)),
        .i_wr_data({i_red_in, i_green_in, i_blue_in}),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_addr),
        .o_rd_data(rd_data)
    );

    assign o_out_valid  = r_out_valid;
    assign o_universe   = r_universe;
    assign o_slot       = r_slot;
    assign o_red_out    = r_pixel[23:16];
    assign o_green_out  = r_pixel[15:8];
    assign o_blue_out   = r_pixel[7:0];
    assign o_packet_end = r_packet_end;
    assign o_frame_end  = r_frame_end;

    // The divider reports completion only while the sequencer waits on it.
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == lpsm_pkg::S_WAIT_COL || r_state == lpsm_pkg::S_WAIT_ROW))
        else $error("divider done outside a wait state");

    // A frame end is always also the end of a panel packet.
    a_frame_end_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> o_packet_end)
        else $error("frame end without packet end");

    // After the last pixel of the last panel the scan counters have wrapped.
    a_frame_end_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> (r_pc == '0 && r_cc == '0 && r_rc == '0))
        else $error("scan counters did not wrap at frame end");

    // The output state is entered only from the frame store read state or held in itself.
    a_out_load_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpsm_pkg::S_OUT) |-> ($past(r_state) == lpsm_pkg::S_READ ||
                                          $past(r_state) == lpsm_pkg::S_OUT))
        else $error("output state entered without a frame store read");

endmodule
